/* src/fmd_pkg.sv */
`default_nettype none
package fmd_pkg;

  // configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t REG_SHAPE_MODE = 3'd0;
  localparam cfg_idx_t REG_POINT_A    = 3'd1;
  localparam cfg_idx_t REG_POINT_B    = 3'd2;
  localparam cfg_idx_t REG_POINT_C    = 3'd3;
  localparam cfg_idx_t REG_POINT_D    = 3'd4;

  localparam logic SHAPE_TRI  = 1'b0;
  localparam logic SHAPE_TRAP = 1'b1;

  // how an item's degree is formed at the end of the chain
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ZERO = 2'd0;
  localparam kind_t KIND_FULL = 2'd1;
  localparam kind_t KIND_DIV  = 2'd2;

  typedef struct packed {
    logic  valid;
    kind_t kind;
  } ctl_t;

endpackage
`default_nettype wire

/* src/fmd_front.sv */
`default_nettype none
module fmd_front #(
  parameter int SW = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               valid_i,
  input  wire logic [SW-1:0]      sample_i,
  input  wire logic               shape_mode_i,
  input  wire logic [SW-1:0]      point_a_i,
  input  wire logic [SW-1:0]      point_b_i,
  input  wire logic [SW-1:0]      point_c_i,
  input  wire logic [SW-1:0]      point_d_i,
  input  wire logic               ready_i,
  output logic                    ready_o,
  output fmd_pkg::ctl_t           ctl_o,
  output logic [SW-1:0]           num_o,
  output logic [SW-1:0]           den_o
);
  import fmd_pkg::*;

  logic signed [SW:0] x, a, b, c, d, right, fall_lo;
  logic signed [SW:0] nh, nl, dh, dl, num_full, den_full;
  kind_t              kind_nxt;
  ctl_t               ctl_r;
  logic [SW-1:0]      num_r, den_r;

  assign x       = {sample_i[SW-1], sample_i};
  assign a       = {point_a_i[SW-1], point_a_i};
  assign b       = {point_b_i[SW-1], point_b_i};
  assign c       = {point_c_i[SW-1], point_c_i};
  assign d       = {point_d_i[SW-1], point_d_i};
  assign right   = (shape_mode_i == SHAPE_TRAP) ? d : c;
  assign fall_lo = (shape_mode_i == SHAPE_TRAP) ? c : b;

  always_comb begin
    kind_nxt = KIND_ZERO;
    nh = x;
    nl = a;
    dh = b;
    dl = a;
    if (x < a || x > right) begin
      kind_nxt = KIND_ZERO;
    end else if (shape_mode_i == SHAPE_TRI && x == b) begin
      kind_nxt = KIND_FULL;
    end else if (shape_mode_i == SHAPE_TRAP && x >= b && x <= c) begin
      kind_nxt = KIND_FULL;
    end else if (shape_mode_i == SHAPE_TRAP && x == a) begin
      kind_nxt = KIND_ZERO;
    end else if (x < b) begin
      kind_nxt = KIND_DIV;
    end else begin
      kind_nxt = KIND_DIV;
      nh = right;
      nl = x;
      dh = right;
      dl = fall_lo;
    end
  end

  // both differences are non-negative and below 2**SW on the divide path
  assign num_full = nh - nl;
  assign den_full = dh - dl;
  assign ready_o  = !ctl_r.valid || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (ready_o) begin
      ctl_r.valid <= valid_i;
      ctl_r.kind  <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o) begin
      num_r <= num_full[SW-1:0];
      den_r <= den_full[SW-1:0];
    end
  end

  assign ctl_o = ctl_r;
  assign num_o = num_r;
  assign den_o = den_r;

endmodule
`default_nettype wire

/* src/fmd_div_cell.sv */
`default_nettype none
module fmd_div_cell #(
  parameter int SW = 16,
  parameter int F  = 15
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fmd_pkg::ctl_t      ctl_i,
  input  wire logic [SW-1:0]      rem_i,
  input  wire logic [SW-1:0]      den_i,
  input  wire logic [F-1:0]       q_i,
  input  wire logic               ready_i,
  output logic                    ready_o,
  output fmd_pkg::ctl_t           ctl_o,
  output logic [SW-1:0]           rem_o,
  output logic [SW-1:0]           den_o,
  output logic [F-1:0]            q_o
);
  import fmd_pkg::*;

  logic [SW+1:0] trial;
  logic          ge;
  logic [SW-1:0] rem_nxt;
  logic [F-1:0]  q_nxt;
  ctl_t          ctl_r;
  logic [SW-1:0] rem_r, den_r;
  logic [F-1:0]  q_r;

  // one restoring step: double the remainder, subtract the divisor if it fits
  assign trial   = {1'b0, rem_i, 1'b0} - {2'b00, den_i};
  assign ge      = !trial[SW+1];
  assign rem_nxt = ge ? trial[SW-1:0] : {rem_i[SW-2:0], 1'b0};
  assign q_nxt   = {q_i[F-2:0], ge};
  assign ready_o = !ctl_r.valid || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (ready_o) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o) begin
      rem_r <= rem_nxt;
      den_r <= den_i;
      q_r   <= q_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign den_o = den_r;
  assign q_o   = q_r;

endmodule
`default_nettype wire

/* src/fuzzy_membership_degree_unit.sv */
`default_nettype none
// Membership degree of a signed sample under a triangular (a,b,c) or trapezoidal
// (a,b,c,d) shape, as unsigned fixed point with DEGREE_FRAC_BITS fraction bits
// (1 << DEGREE_FRAC_BITS is full). A new item is taken every cycle unless in_stall
// is raised; each item passes through the classification stage, the chain of
// restoring divider cells (one per quotient bit), and the output register.
// Stages hold their item when the next one is full and cannot pass its own item
// on, so bubbles close up while the output is stalled.
// Configure the points through cfg_wr_en/cfg_index/cfg_wdata only while idle.
module fuzzy_membership_degree_unit #(
  parameter int SAMPLE_WIDTH     = 16,
  parameter int DEGREE_FRAC_BITS = 15
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire fmd_pkg::cfg_idx_t           cfg_index,
  input  wire logic [SAMPLE_WIDTH-1:0]     cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [SAMPLE_WIDTH-1:0]     in_sample,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [DEGREE_FRAC_BITS:0]        out_degree
);
  import fmd_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int F  = DEGREE_FRAC_BITS;
  localparam logic [F:0] FULL = {1'b1, {F{1'b0}}};

  logic          shape_mode_r;
  logic [SW-1:0] point_a_r, point_b_r, point_c_r, point_d_r;

  ctl_t          ctl_w [0:F];
  logic [SW-1:0] rem_w [0:F];
  logic [SW-1:0] den_w [0:F];
  logic [F-1:0]  q_w   [0:F];
  logic          rdy_w [0:F];
  logic          front_rdy;
  logic          out_rdy;
  logic          out_valid_r;
  logic [F:0]    out_degree_r;
  logic [F:0]    degree_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_mode_r <= SHAPE_TRI;
      point_a_r    <= '0;
      point_b_r    <= '0;
      point_c_r    <= '0;
      point_d_r    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SHAPE_MODE: shape_mode_r <= cfg_wdata[0];
        REG_POINT_A:    point_a_r    <= cfg_wdata;
        REG_POINT_B:    point_b_r    <= cfg_wdata;
        REG_POINT_C:    point_c_r    <= cfg_wdata;
        REG_POINT_D:    point_d_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  fmd_front #(.SW(SW)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid_i      (in_valid),
    .sample_i     (in_sample),
    .shape_mode_i (shape_mode_r),
    .point_a_i    (point_a_r),
    .point_b_i    (point_b_r),
    .point_c_i    (point_c_r),
    .point_d_i    (point_d_r),
    .ready_i      (rdy_w[0]),
    .ready_o      (front_rdy),
    .ctl_o        (ctl_w[0]),
    .num_o        (rem_w[0]),
    .den_o        (den_w[0])
  );

  assign q_w[0] = '0;

  for (genvar k = 0; k < F; k++) begin : g_cell
    fmd_div_cell #(.SW(SW), .F(F)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (ctl_w[k]),
      .rem_i   (rem_w[k]),
      .den_i   (den_w[k]),
      .q_i     (q_w[k]),
      .ready_i (rdy_w[k+1]),
      .ready_o (rdy_w[k]),
      .ctl_o   (ctl_w[k+1]),
      .rem_o   (rem_w[k+1]),
      .den_o   (den_w[k+1]),
      .q_o     (q_w[k+1])
    );
  end

  assign out_rdy  = !out_valid_r || !out_stall;
  assign rdy_w[F] = out_rdy;
  assign in_stall = !front_rdy;

  always_comb begin
    case (ctl_w[F].kind)
      KIND_FULL: degree_nxt = FULL;
      KIND_DIV:  degree_nxt = {1'b0, q_w[F]};
      default:   degree_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= ctl_w[F].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      out_degree_r <= degree_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_degree = out_degree_r;

  // divide path only ever sees a proper fraction with a non-zero divisor
  a_div_operands: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_w[0].valid && ctl_w[0].kind == KIND_DIV) |-> (den_w[0] != '0 && rem_w[0] < den_w[0]))
    else $error("divide operands out of range");

  a_degree_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_degree <= FULL))
    else $error("degree above full");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule
`default_nettype wire
